### rtl/core/pil_pkg.sv
package pil_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int VALUE_W       = 32;
    localparam int MODE_W        = 2;
    localparam int POS_IN_W      = 5;
    localparam int STATUS_W      = 2;
    localparam int COUNT_OUT_W   = 5;

    // Default list capacity.
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_READ   = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // Write command broadcast to every cell of the chain.
    typedef struct packed {
        logic               en;
        logic [VALUE_W-1:0] value;
    } wr_cmd_t;

    // Read probe that travels one cell per cycle along the chain.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] data;
    } probe_t;

endpackage

### rtl/core/pil_req_if.sv
interface pil_req_if
    import pil_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [POS_IN_W-1:0] position;
    logic [VALUE_W-1:0]  item_value;

    modport source (output valid, output mode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input mode, input position, input item_value,
                    output ready);
endinterface

### rtl/core/pil_rsp_if.sv
interface pil_rsp_if
    import pil_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [VALUE_W-1:0]     read_value;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] element_count;

    modport source (output valid, output read_value, output status, output element_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input element_count,
                    output ready);
endinterface

### rtl/core/positional_insert_list.sv
// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells.
// Requests arrive on the req channel (mode, position, item_value) and each
// request produces exactly one transaction on the rsp channel (read_value,
// status, element_count). Both channels use a valid/ready handshake; a
// transaction moves on a rising clock edge with valid and ready high.
// For append and insert, every cell compares its own index with the write
// position and either loads the new value, loads its left neighbor, or holds.
// The response to these and to every rejected request is registered as
// the request is accepted, so a new one may follow every cycle while rsp
// is not stalled. An in-range read sends a probe down the chain, one cell
// per cycle; the response is registered when the probe leaves the last cell.
// No request is taken while a read probe is in flight, so the next request
// is accepted only after the probe has left the chain.
// When rsp is stalled, the response register holds its transaction and req
// stays low on ready until the cycle in which the response is taken.
// Reset clears the element count, the probe chain and the response valid;
// the cell contents stay undefined and are never read before written.
module positional_insert_list
    import pil_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    pil_req_if.sink   req,
    pil_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    // Compare width covers both the count and the position field.
    localparam int POS_W = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;
    localparam logic [POS_W-1:0] FULL_CNT = POS_W'(DEPTH);

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [POS_W-1:0]       rd_pos_reg;
    logic                   probe_start_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic [VALUE_W-1:0]     read_value_reg;
    logic [VALUE_W-1:0]     read_value_next;
    status_t                status_reg;
    status_t                status_next;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic                   rsp_load;

    logic                   accept;
    logic                   start_read;
    logic [POS_W-1:0]       pos_ext;
    logic [POS_W-1:0]       cnt_ext;
    logic [POS_W-1:0]       wr_pos;
    wr_cmd_t                wr;
    status_t                quick_status;
    logic                   quick_rsp;

    logic [VALUE_W-1:0]     entry [DEPTH];
    probe_t                 probe [DEPTH+1];
    logic [DEPTH:0]         probe_vld;

    assign pos_ext  = POS_W'(req.position);
    assign cnt_ext  = POS_W'(count_reg);
    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    // Request decode. Writes and rejected requests answer at once; an
    // in-range read launches a probe.
    always_comb
    begin
        wr.en        = 1'b0;
        wr.value     = req.item_value;
        wr_pos       = cnt_ext;
        start_read   = 1'b0;
        quick_status = ST_OK;
        quick_rsp    = 1'b0;
        if (accept)
        begin
            case (mode_t'(req.mode))
                MODE_APPEND:
                begin
                    quick_rsp = 1'b1;
                    if (cnt_ext == FULL_CNT)
                    begin
                        quick_status = ST_FULL;
                    end
                    else
                    begin
                        wr.en = 1'b1;
                    end
                end
                MODE_INSERT:
                begin
                    quick_rsp = 1'b1;
                    if (pos_ext > cnt_ext)
                    begin
                        quick_status = ST_RANGE;
                    end
                    else if (cnt_ext == FULL_CNT)
                    begin
                        quick_status = ST_FULL;
                    end
                    else
                    begin
                        wr.en  = 1'b1;
                        wr_pos = pos_ext;
                    end
                end
                MODE_READ:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        quick_rsp    = 1'b1;
                        quick_status = ST_RANGE;
                    end
                    else
                    begin
                        start_read = 1'b1;
                    end
                end
                default:
                begin
                    quick_rsp    = 1'b1;
                    quick_status = ST_RANGE;
                end
            endcase
        end
    end

    assign count_next = wr.en ? (count_reg + CNT_W'(1)) : count_reg;

    // Sequencer: idle, or waiting for the read probe to leave the chain.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (probe[DEPTH].valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Response register: loaded by an immediate answer or by the probe.
    always_comb
    begin
        rsp_load        = quick_rsp || probe[DEPTH].valid;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        read_value_next = '0;
        status_next     = quick_status;
        if (probe[DEPTH].valid)
        begin
            read_value_next = probe[DEPTH].data;
            status_next     = ST_OK;
        end
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
            probe_start_reg <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            rsp_valid_reg   <= rsp_valid_next;
            probe_start_reg <= start_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_pos_reg <= pos_ext;
        end
        if (rsp_load)
        begin
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
            count_out_reg  <= COUNT_OUT_W'(count_next);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_value    = read_value_reg;
    assign rsp.status        = status_reg;
    assign rsp.element_count = count_out_reg;

    // The chain of cells. The probe enters at the head in the cycle after the
    // read is accepted, with the read index held in rd_pos_reg.
    assign probe[0].valid = probe_start_reg;
    assign probe[0].data  = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] left_entry;
        if (i == 0)
        begin : g_head
            assign left_entry = '0;
        end
        else
        begin : g_body
            assign left_entry = entry[i-1];
        end

        pil_cell #(
            .INDEX (i),
            .POS_W (POS_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr         (wr),
            .wr_pos     (wr_pos),
            .wr_last    (cnt_ext),
            .rd_pos     (rd_pos_reg),
            .left_entry (left_entry),
            .entry      (entry[i]),
            .probe_in   (probe[i]),
            .probe_out  (probe[i+1])
        );
    end

    for (genvar i = 0; i <= DEPTH; i++)
    begin : g_vld
        assign probe_vld[i] = probe[i].valid;
    end

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        POS_W'(count_reg) <= FULL_CNT)
        else $error("element count exceeds capacity");

    // Each accepted write grows the list by exactly one entry.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("write did not advance the count by one");

    // At most one read probe is in flight along the chain.
    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(probe_vld))
        else $error("more than one read probe in the chain");

    // A probe leaves the chain only while the sequencer waits for it.
    a_probe_owner: assert property (@(posedge clk) disable iff (!rst_n)
        probe[DEPTH].valid |-> (state_reg == S_READ))
        else $error("read probe finished outside a read");

    // The list contents do not change while a read is in flight.
    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (!wr.en && $stable(count_reg)))
        else $error("list changed during a read");

endmodule

### rtl/core/pil_cell.sv
module pil_cell
    import pil_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int POS_W = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wr_cmd_t            wr,
    input  logic [POS_W-1:0]   wr_pos,
    input  logic [POS_W-1:0]   wr_last,
    input  logic [POS_W-1:0]   rd_pos,
    input  logic [VALUE_W-1:0] left_entry,
    output logic [VALUE_W-1:0] entry,
    input  probe_t             probe_in,
    output probe_t             probe_out
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               entry_load;
    logic               probe_valid_reg;
    logic [VALUE_W-1:0] probe_data_reg;
    logic [VALUE_W-1:0] probe_data_next;

    // The cell at the write position takes the new value; cells behind it, up
    // to the first free cell at wr_last, take their left neighbor's value.
    always_comb
    begin
        entry_load = 1'b0;
        entry_next = left_entry;
        if (wr.en && (wr_pos == MY_IDX))
        begin
            entry_load = 1'b1;
            entry_next = wr.value;
        end
        else if (wr.en && (MY_IDX > wr_pos) && (MY_IDX <= wr_last))
        begin
            entry_load = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_load)
        begin
            entry_reg <= entry_next;
        end
    end

    // The probe picks up this entry when it passes the addressed cell.
    assign probe_data_next = (probe_in.valid && (rd_pos == MY_IDX)) ? entry_reg
                                                                    : probe_in.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
        end
        else
        begin
            probe_valid_reg <= probe_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_data_reg <= probe_data_next;
    end

    assign entry           = entry_reg;
    assign probe_out.valid = probe_valid_reg;
    assign probe_out.data  = probe_data_reg;

endmodule
